[rtl/odo_pkg.sv]
// ----------------------------------------------------------------------------
// odo_pkg
// Types, codes and constants shared by the odometry block.
// ----------------------------------------------------------------------------
package odo_pkg;

   typedef struct packed {
      logic signed [15:0] left_count;
      logic signed [15:0] right_count;
      logic [19:0]        elapsed_us;
   } req_type;

   typedef struct packed {
      logic signed [47:0] pos_x;
      logic signed [47:0] pos_y;
      logic [31:0]        heading;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] yaw_rate;
   } rsp_type;

   // datapath operations
   localparam logic [3:0] OP_NONE     = 4'd0;
   localparam logic [3:0] OP_PRIME    = 4'd1;
   localparam logic [3:0] OP_LOAD     = 4'd2;
   localparam logic [3:0] OP_MUL_DL   = 4'd3;
   localparam logic [3:0] OP_MUL_DR   = 4'd4;
   localparam logic [3:0] OP_MUL_RAD  = 4'd5;
   localparam logic [3:0] OP_MUL_BAM  = 4'd6;
   localparam logic [3:0] OP_CORDIC   = 4'd7;
   localparam logic [3:0] OP_MUL_DX   = 4'd8;
   localparam logic [3:0] OP_MUL_DY   = 4'd9;
   localparam logic [3:0] OP_ACCUM    = 4'd10;
   localparam logic [3:0] OP_MUL_RATE = 4'd11;
   localparam logic [3:0] OP_DIV_RATE = 4'd12;
   localparam logic [3:0] OP_EMIT     = 4'd13;

   // velocity channel select
   localparam logic [1:0] SEL_VX  = 2'd0;
   localparam logic [1:0] SEL_VY  = 2'd1;
   localparam logic [1:0] SEL_YAW = 2'd2;

   typedef struct packed {
      logic       start;
      logic [3:0] op;
      logic [1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic done;
   } stat_type;

   // register map
   localparam int          ADDR_W              = 3;
   localparam logic        REG_DIST_PER_COUNT  = 1'b0;
   localparam logic        REG_INV_WHEEL_BASE  = 1'b1;
   localparam logic [31:0] DIST_PER_COUNT_RST  = 32'd429497;
   localparam logic [31:0] INV_WHEEL_BASE_RST  = 32'd33554432;

   // 2^32 / (2*pi) in Q0.32
   localparam logic [31:0]        INV_TWO_PI  = 32'd683565276;
   // 1e6 / 2^6: with the 4*us divisor, us-to-s and the Q.24 -> Q.16 shift
   localparam logic [31:0]        RATE_SCALE  = 32'd15625;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

   localparam logic [29:0] ATAN_TAB [32] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
      30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
      30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
   };

endpackage

[rtl/differential_drive_odometry.sv]
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Wheel encoder odometry: pose integration and velocity estimate.
// ----------------------------------------------------------------------------
// Input channel req_*: one beat carries both raw encoder counters and the
// microseconds since the previous beat. Result channel rsp_*: pose (x, y,
// heading) and saturated velocities. Both use valid/stall; a beat moves when
// valid is high and stall low. dist_per_count and inv_wheel_base sit on the
// APB port at byte addresses 0 and 4; write them only while the block idles.
// An update runs through a shared shift-add multiplier (nine products), a
// CORDIC rotation of CORDIC_STEPS steps and three 64-step divisions.
// req_stall is high from acceptance until the result is loaded. A beat
// with zero elapsed time, and the first beat after reset, give no result.
// Reset clears pose and counters and restores the register defaults. A
// stalled result holds; the next item is taken meanwhile and its result
// waits until the slot frees.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  odo_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output odo_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [odo_pkg::ADDR_W-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic [31:0] dpc_ff, dpc_in, iwb_ff, iwb_in;
   logic        wr_en;
   odo_pkg::cmd_type  cmd;
   odo_pkg::stat_type stat;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      dpc_in = dpc_ff;
      iwb_in = iwb_ff;
      if (wr_en) begin
         unique case (paddr[2])
            odo_pkg::REG_DIST_PER_COUNT: dpc_in = pwdata;
            odo_pkg::REG_INV_WHEEL_BASE: iwb_in = pwdata;
            default: ;
         endcase
      end
      unique case (paddr[2])
         odo_pkg::REG_DIST_PER_COUNT: prdata = dpc_ff;
         odo_pkg::REG_INV_WHEEL_BASE: prdata = iwb_ff;
         default:                     prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dpc_ff <= odo_pkg::DIST_PER_COUNT_RST;
         iwb_ff <= odo_pkg::INV_WHEEL_BASE_RST;
      end else begin
         dpc_ff <= dpc_in;
         iwb_ff <= iwb_in;
      end
   end

   odo_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_us_zero (req_data.elapsed_us == 20'd0),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .stat        (stat)
   );

   odo_datapath #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_data       (req_data),
      .dist_per_count (dpc_ff),
      .inv_wheel_base (iwb_ff),
      .rsp_data       (rsp_data)
   );

endmodule

[rtl/odo_mul.sv]
// ----------------------------------------------------------------------------
// odo_mul
// Shift-add unsigned multiplier, 56 x 32 bits, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module odo_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [55:0] a_in,
   input  logic [31:0] b_in,
   output logic        done,
   output logic [87:0] product
);

   logic [87:0] p_ff, p_in;
   logic [55:0] a_ff, a_in_nx;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [56:0] sum;

   always_comb begin
      p_in    = p_ff;
      a_in_nx = a_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sum     = {1'b0, p_ff[87:32]} + (p_ff[0] ? {1'b0, a_ff} : 57'd0);
      if (start) begin
         p_in    = {56'd0, b_in};
         a_in_nx = a_in;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         p_in   = {sum, p_ff[31:1]};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      a_ff <= a_in_nx;
      if (reset) begin
         cnt_ff  <= 5'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = p_ff;

endmodule

[rtl/odo_div.sv]
// ----------------------------------------------------------------------------
// odo_div
// Restoring divider, 64-bit dividend by 22-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module odo_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [21:0] den,
   output logic        done,
   output logic [63:0] quot
);

   logic [63:0] quo_ff, quo_in;
   logic [21:0] rem_ff, rem_in;
   logic [21:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [22:0] trial;
   logic        ge;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]};
      ge      = trial >= {1'b0, den_ff};
      if (start) begin
         quo_in  = num;
         rem_in  = 22'd0;
         den_in  = den;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? 22'(trial - {1'b0, den_ff}) : trial[21:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= 6'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

[rtl/odo_datapath.sv]
// ----------------------------------------------------------------------------
// odo_datapath
// Pose state, shared multiplier and divider, CORDIC rotator, result register.
// ----------------------------------------------------------------------------
module odo_datapath #(
   parameter int CORDIC_STEPS
) (
   input  logic             clock,
   input  logic             reset,
   input  odo_pkg::cmd_type cmd,
   output odo_pkg::stat_type stat,
   input  odo_pkg::req_type req_data,
   input  logic [31:0]      dist_per_count,
   input  logic [31:0]      inv_wheel_base,
   output odo_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CORDIC_STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

   logic [15:0] last_l_ff, last_l_in, last_r_ff, last_r_in;
   logic [15:0] dlt_l_ff, dlt_l_in, dlt_r_ff, dlt_r_in;
   logic [19:0] us_ff, us_in;
   logic [47:0] dl_ff, dl_in, dr_ff, dr_in;
   logic [55:0] rad_ff, rad_in;
   logic        neg_ff, neg_in;
   logic [31:0] mid_ff, mid_in, dth_ff, dth_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [1:0]  q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic        run_ff, run_in, cdone_ff, cdone_in;
   logic [47:0] dxm_ff, dxm_in, dym_ff, dym_in;
   logic        dxn_ff, dxn_in, dyn_ff, dyn_in;
   logic [47:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [31:0] acc_h_ff, acc_h_in;
   logic [63:0] num_ff, num_in;
   logic [31:0] vx_ff, vx_in, vy_ff, vy_in, yr_ff, yr_in;
   logic [3:0]  op_ff, op_in;
   logic [1:0]  sel_ff, sel_in;
   odo_pkg::rsp_type rsp_ff, rsp_in;

   logic [48:0] dsum, diff, diff_mag;
   logic [47:0] dc, dc_mag, lprod, rprod, step_x, step_y;
   logic        dc_neg;
   logic [16:0] lext, rext, lmag, rmag;
   logic signed [33:0] c, s, sx, sy, at;
   logic [31:0] c_mag, s_mag, ang_t, ru, half;
   logic [53:0] bam;
   logic [4:0]  k;
   logic [55:0] mul_a;
   logic [31:0] mul_b;
   logic        mul_start, mul_done, div_start, div_done;
   logic [87:0] mul_p;
   logic [63:0] div_q;

   function automatic logic [31:0] sat_rate(input logic [63:0] q, input logic neg);
      logic [31:0] r;
      if (neg) begin
         r = (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q);
      end else begin
         r = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end
      return r;
   endfunction

   // wheel distance terms
   always_comb begin
      dsum     = {dl_ff[47], dl_ff} + {dr_ff[47], dr_ff};
      dc       = dsum[48:1];
      dc_neg   = dsum[48];
      dc_mag   = dc_neg ? 48'd0 - dc : dc;
      diff     = {dr_ff[47], dr_ff} - {dl_ff[47], dl_ff};
      diff_mag = diff[48] ? 49'd0 - diff : diff;
      lext     = {dlt_l_ff[15], dlt_l_ff};
      rext     = {dlt_r_ff[15], dlt_r_ff};
      lmag     = lext[16] ? 17'd0 - lext : lext;
      rmag     = rext[16] ? 17'd0 - rext : rext;
      lprod    = mul_p[47:0];
      rprod    = mul_p[47:0];
      bam      = mul_p[85:32];
      half     = neg_ff ? 32'd0 - bam[32:1] : bam[32:1];
      step_x   = dxn_ff ? 48'd0 - dxm_ff : dxm_ff;
      step_y   = dyn_ff ? 48'd0 - dym_ff : dym_ff;
   end

   // quadrant fold back and CORDIC step terms
   always_comb begin
      case (q_ff)
         2'd0: begin c = x_ff;  s = y_ff;  end
         2'd1: begin c = -y_ff; s = x_ff;  end
         2'd2: begin c = -x_ff; s = -y_ff; end
         default: begin c = y_ff; s = -x_ff; end
      endcase
      c_mag = c[33] ? 32'(-c) : 32'(c);
      s_mag = s[33] ? 32'(-s) : 32'(s);
      k     = 5'(cnt_ff);
      sx    = y_ff >>> k;
      sy    = x_ff >>> k;
      at    = $signed({4'd0, odo_pkg::ATAN_TAB[k]});
      ang_t = mid_ff + 32'h2000_0000;
      ru    = mid_ff - {ang_t[31:30], 30'd0};
   end

   // multiplier operand select
   always_comb begin
      mul_a     = 56'd0;
      mul_b     = 32'd0;
      mul_start = 1'b0;
      unique case (cmd.op) inside
         odo_pkg::OP_MUL_DL:   begin mul_a = 56'(lmag); mul_b = dist_per_count; end
         odo_pkg::OP_MUL_DR:   begin mul_a = 56'(rmag); mul_b = dist_per_count; end
         odo_pkg::OP_MUL_RAD:  begin mul_a = 56'(diff_mag); mul_b = inv_wheel_base; end
         odo_pkg::OP_MUL_BAM:  begin mul_a = rad_ff; mul_b = odo_pkg::INV_TWO_PI; end
         odo_pkg::OP_MUL_DX:   begin mul_a = 56'(dc_mag); mul_b = c_mag; end
         odo_pkg::OP_MUL_DY:   begin mul_a = 56'(dc_mag); mul_b = s_mag; end
         odo_pkg::OP_MUL_RATE: begin
            mul_b = odo_pkg::RATE_SCALE;
            case (cmd.sel)
               odo_pkg::SEL_VX: mul_a = 56'(dxm_ff);
               odo_pkg::SEL_VY: mul_a = 56'(dym_ff);
               default:         mul_a = 56'(rad_ff[55:8]);
            endcase
         end
         default: ;
      endcase
      unique case (cmd.op) inside
         odo_pkg::OP_MUL_DL, odo_pkg::OP_MUL_DR, odo_pkg::OP_MUL_RAD, odo_pkg::OP_MUL_BAM,
         odo_pkg::OP_MUL_DX, odo_pkg::OP_MUL_DY, odo_pkg::OP_MUL_RATE:
            mul_start = cmd.start;
         default: mul_start = 1'b0;
      endcase
      div_start = cmd.start && (cmd.op == odo_pkg::OP_DIV_RATE);
   end

   // next state
   always_comb begin
      last_l_in = last_l_ff; last_r_in = last_r_ff;
      dlt_l_in  = dlt_l_ff;  dlt_r_in  = dlt_r_ff;
      us_in     = us_ff;
      dl_in     = dl_ff;     dr_in     = dr_ff;
      rad_in    = rad_ff;    neg_in    = neg_ff;
      mid_in    = mid_ff;    dth_in    = dth_ff;
      x_in      = x_ff;      y_in      = y_ff;   z_in = z_ff;  q_in = q_ff;
      cnt_in    = cnt_ff;    run_in    = run_ff; cdone_in = 1'b0;
      dxm_in    = dxm_ff;    dym_in    = dym_ff;
      dxn_in    = dxn_ff;    dyn_in    = dyn_ff;
      acc_x_in  = acc_x_ff;  acc_y_in  = acc_y_ff; acc_h_in = acc_h_ff;
      num_in    = num_ff;
      vx_in     = vx_ff;     vy_in     = vy_ff;  yr_in = yr_ff;
      op_in     = op_ff;     sel_in    = sel_ff;
      rsp_in    = rsp_ff;

      if (cmd.start) begin
         op_in  = cmd.op;
         sel_in = cmd.sel;
         unique case (cmd.op) inside
            odo_pkg::OP_PRIME: begin
               last_l_in = req_data.left_count;
               last_r_in = req_data.right_count;
            end
            odo_pkg::OP_LOAD: begin
               dlt_l_in  = req_data.left_count - last_l_ff;
               dlt_r_in  = req_data.right_count - last_r_ff;
               last_l_in = req_data.left_count;
               last_r_in = req_data.right_count;
               us_in     = req_data.elapsed_us;
            end
            odo_pkg::OP_CORDIC: begin
               // residual angle lies within one octant either side of the axis
               q_in   = ang_t[31:30];
               z_in   = $signed({{2{ru[31]}}, ru});
               x_in   = odo_pkg::CORDIC_GAIN;
               y_in   = 34'sd0;
               cnt_in = '0;
               run_in = 1'b1;
            end
            odo_pkg::OP_ACCUM: begin
               acc_x_in = acc_x_ff + step_x;
               acc_y_in = acc_y_ff + step_y;
               acc_h_in = acc_h_ff + dth_ff;
            end
            odo_pkg::OP_EMIT: begin
               rsp_in.pos_x    = acc_x_ff;
               rsp_in.pos_y    = acc_y_ff;
               rsp_in.heading  = acc_h_ff;
               rsp_in.vel_x    = vx_ff;
               rsp_in.vel_y    = vy_ff;
               rsp_in.yaw_rate = yr_ff;
            end
            default: ;
         endcase
      end

      if (run_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - sx; y_in = y_ff + sy; z_in = z_ff - at;
         end else begin
            x_in = x_ff + sx; y_in = y_ff - sy; z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            run_in   = 1'b0;
            cdone_in = 1'b1;
         end
      end

      if (mul_done) begin
         unique case (op_ff) inside
            odo_pkg::OP_MUL_DL:  dl_in = dlt_l_ff[15] ? 48'd0 - lprod : lprod;
            odo_pkg::OP_MUL_DR:  dr_in = dlt_r_ff[15] ? 48'd0 - rprod : rprod;
            odo_pkg::OP_MUL_RAD: begin
               rad_in = mul_p[79:24];
               neg_in = diff[48];
            end
            odo_pkg::OP_MUL_BAM: begin
               dth_in = neg_ff ? 32'd0 - bam[31:0] : bam[31:0];
               mid_in = acc_h_ff + half;
            end
            odo_pkg::OP_MUL_DX: begin
               dxm_in = mul_p[85:38];
               dxn_in = dc_neg ^ c[33];
            end
            odo_pkg::OP_MUL_DY: begin
               dym_in = mul_p[85:38];
               dyn_in = dc_neg ^ s[33];
            end
            odo_pkg::OP_MUL_RATE: num_in = mul_p[63:0];
            default: ;
         endcase
      end

      if (div_done) begin
         case (sel_ff)
            odo_pkg::SEL_VX: vx_in = sat_rate(div_q, dxn_ff);
            odo_pkg::SEL_VY: vy_in = sat_rate(div_q, dyn_ff);
            default:         yr_in = sat_rate(div_q, neg_ff);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      dlt_l_ff <= dlt_l_in; dlt_r_ff <= dlt_r_in;
      us_ff    <= us_in;
      dl_ff    <= dl_in;    dr_ff    <= dr_in;
      rad_ff   <= rad_in;   neg_ff   <= neg_in;
      mid_ff   <= mid_in;   dth_ff   <= dth_in;
      x_ff     <= x_in;     y_ff     <= y_in;   z_ff <= z_in;  q_ff <= q_in;
      dxm_ff   <= dxm_in;   dym_ff   <= dym_in;
      dxn_ff   <= dxn_in;   dyn_ff   <= dyn_in;
      num_ff   <= num_in;
      vx_ff    <= vx_in;    vy_ff    <= vy_in;  yr_ff <= yr_in;
      sel_ff   <= sel_in;
      rsp_ff   <= rsp_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         last_l_ff <= 16'd0;
         last_r_ff <= 16'd0;
         acc_x_ff  <= 48'd0;
         acc_y_ff  <= 48'd0;
         acc_h_ff  <= 32'd0;
         run_ff    <= 1'b0;
         cdone_ff  <= 1'b0;
         op_ff     <= odo_pkg::OP_NONE;
      end else begin
         last_l_ff <= last_l_in;
         last_r_ff <= last_r_in;
         acc_x_ff  <= acc_x_in;
         acc_y_ff  <= acc_y_in;
         acc_h_ff  <= acc_h_in;
         run_ff    <= run_in;
         cdone_ff  <= cdone_in;
         op_ff     <= op_in;
      end
   end

   odo_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a_in    (mul_a),
      .b_in    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   odo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   ({us_ff, 2'b00}),
      .done  (div_done),
      .quot  (div_q)
   );

   assign stat.done = mul_done | div_done | cdone_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/odo_ctrl.sv]
// ----------------------------------------------------------------------------
// odo_ctrl
// Sequencer: handshakes, priming, and the order of datapath operations.
// ----------------------------------------------------------------------------
module odo_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_us_zero,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output odo_pkg::cmd_type  cmd,
   input  odo_pkg::stat_type stat
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_MUL_DL   = 4'd1;
   localparam logic [3:0] ST_MUL_DR   = 4'd2;
   localparam logic [3:0] ST_MUL_RAD  = 4'd3;
   localparam logic [3:0] ST_MUL_BAM  = 4'd4;
   localparam logic [3:0] ST_CORDIC   = 4'd5;
   localparam logic [3:0] ST_MUL_DX   = 4'd6;
   localparam logic [3:0] ST_MUL_DY   = 4'd7;
   localparam logic [3:0] ST_ACCUM    = 4'd8;
   localparam logic [3:0] ST_RATE_MUL = 4'd9;
   localparam logic [3:0] ST_RATE_DIV = 4'd10;
   localparam logic [3:0] ST_EMIT     = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       issued_ff, issued_in;
   logic       primed_ff, primed_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       waiting;
   logic [3:0] next_state;

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      primed_in    = primed_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.start    = 1'b0;
      cmd.op       = odo_pkg::OP_NONE;
      cmd.sel      = idx_ff;
      waiting      = 1'b0;
      next_state   = state_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // zero elapsed time drops the beat without touching state
            if (req_valid && !req_us_zero) begin
               cmd.start = 1'b1;
               if (!primed_ff) begin
                  cmd.op    = odo_pkg::OP_PRIME;
                  primed_in = 1'b1;
               end else begin
                  cmd.op   = odo_pkg::OP_LOAD;
                  state_in = ST_MUL_DL;
               end
            end
         end
         ST_MUL_DL:  begin waiting = 1'b1; cmd.op = odo_pkg::OP_MUL_DL;  next_state = ST_MUL_DR;  end
         ST_MUL_DR:  begin waiting = 1'b1; cmd.op = odo_pkg::OP_MUL_DR;  next_state = ST_MUL_RAD; end
         ST_MUL_RAD: begin waiting = 1'b1; cmd.op = odo_pkg::OP_MUL_RAD; next_state = ST_MUL_BAM; end
         ST_MUL_BAM: begin waiting = 1'b1; cmd.op = odo_pkg::OP_MUL_BAM; next_state = ST_CORDIC;  end
         ST_CORDIC:  begin waiting = 1'b1; cmd.op = odo_pkg::OP_CORDIC;  next_state = ST_MUL_DX;  end
         ST_MUL_DX:  begin waiting = 1'b1; cmd.op = odo_pkg::OP_MUL_DX;  next_state = ST_MUL_DY;  end
         ST_MUL_DY:  begin waiting = 1'b1; cmd.op = odo_pkg::OP_MUL_DY;  next_state = ST_ACCUM;   end
         ST_ACCUM: begin
            cmd.start = 1'b1;
            cmd.op    = odo_pkg::OP_ACCUM;
            idx_in    = odo_pkg::SEL_VX;
            state_in  = ST_RATE_MUL;
         end
         ST_RATE_MUL: begin
            waiting    = 1'b1;
            cmd.op     = odo_pkg::OP_MUL_RATE;
            next_state = ST_RATE_DIV;
         end
         ST_RATE_DIV: begin
            waiting    = 1'b1;
            cmd.op     = odo_pkg::OP_DIV_RATE;
            next_state = (idx_ff == odo_pkg::SEL_YAW) ? ST_EMIT : ST_RATE_MUL;
            if (stat.done && idx_ff != odo_pkg::SEL_YAW) begin
               idx_in = idx_ff + 2'd1;
            end
         end
         ST_EMIT: begin
            // hold off while the previous result beat is still stalled
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.start    = 1'b1;
               cmd.op       = odo_pkg::OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (waiting) begin
         cmd.start = !issued_ff;
         issued_in = 1'b1;
         if (stat.done) begin
            issued_in = 1'b0;
            state_in  = next_state;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         primed_ff    <= 1'b0;
         idx_ff       <= odo_pkg::SEL_VX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         primed_ff    <= primed_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> issued_ff)
      else $error("unit done without an issued operation");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(cmd.start && cmd.op == odo_pkg::OP_EMIT))
      else $error("result register loaded over a stalled beat");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd3)
      else $error("velocity select out of range");
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && cmd.op == odo_pkg::OP_EMIT) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("emit did not raise result valid");
`endif

endmodule
